// File: rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants and types of the buddy block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;

  localparam int PAGE_ORDER   = 12;
  localparam int REGION_ORDER = 20;
  localparam int PAGE_W       = REGION_ORDER - PAGE_ORDER;
  localparam int NPAGES       = 1 << PAGE_W;
  localparam int NORDERS      = PAGE_W + 1;
  localparam int LI_W         = $clog2(NORDERS);
  localparam int LINK_W       = PAGE_W + 1;
  localparam int SIZE_W       = REGION_ORDER + 1;
  localparam int ORD_W        = 5;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NPAGES);

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [LI_W-1:0]   li;
    logic [PAGE_W-1:0] page;
  } job_t;

  typedef struct packed {
    logic              in_use;
    logic [ORD_W-1:0]  order;
  } meta_t;

endpackage
`default_nettype wire

// File: rtl/bba_ram.sv
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/bba_front.sv
// ----------------------------------------------------------------------------
// bba_front
// Accepts command beats, rounds sizes to an order, and queues jobs.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_front import bba_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  output logic                         cmd_stall,
  input  wire logic                    command,
  input  wire logic [SIZE_W-1:0]       request_size,
  input  wire logic [REGION_ORDER-1:0] free_offset,
  output job_t                         job,
  output logic                         job_valid,
  input  wire logic                    job_pop
);

  job_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       fit;
  logic [LI_W-1:0] want_li;
  job_t       job_in;
  logic       push;

  always_comb begin
    fit     = 1'b0;
    want_li = '0;
    for (int i = NORDERS - 1; i >= 0; i--) begin
      if (request_size <= SIZE_W'(64'd1 << (PAGE_ORDER + i))) begin
        fit     = 1'b1;
        want_li = LI_W'(i);
      end
    end
    job_in.kind = command ? KIND_FREE : (fit ? KIND_ALLOC : KIND_FAIL);
    job_in.li   = want_li;
    job_in.page = free_offset[REGION_ORDER-1:PAGE_ORDER];
  end

  assign cmd_stall = (count == 2'd2);
  assign push      = cmd_valid && !cmd_stall;
  assign job_valid = (count != 2'd0);
  assign job       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        fifo[wr_ptr] <= job_in;
        wr_ptr       <= ~wr_ptr;
      end
      if (job_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(job_pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/bba_back.sv
// ----------------------------------------------------------------------------
// bba_back
// Carries out allocate and free jobs on the free lists and page tables.
// ----------------------------------------------------------------------------
`default_nettype none
module bba_back import bba_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire job_t                    job,
  input  wire logic                    job_valid,
  output logic                         job_pop,
  output logic                         res_valid,
  input  wire logic                    res_stall,
  output logic                         status,
  output logic [REGION_ORDER-1:0]      block_offset,
  output logic [ORD_W-1:0]             block_order
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_UNLINK = 10'b0000000010,
    S_SPLIT  = 10'b0000000100,
    S_AP1    = 10'b0000001000,
    S_AP2    = 10'b0000010000,
    S_FCHK   = 10'b0000100000,
    S_FLOOP  = 10'b0001000000,
    S_FBUD   = 10'b0010000000,
    S_FFIN   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t            st;
  logic [PAGE_W-1:0] p;
  logic [LI_W-1:0]   k;
  logic [LI_W-1:0]   wi;
  logic [PAGE_W-1:0] ap_pg;
  logic              ap_free;
  logic [LINK_W-1:0] tail;
  logic              init_head;
  logic [LINK_W-1:0] first [NORDERS];
  logic [LINK_W-1:0] last  [NORDERS];
  logic [NPAGES-1:0] meta_valid;
  logic [PAGE_W-1:0] rd_page;
  logic              rd_vld;
  logic              rd_init;

  logic              re;
  logic [PAGE_W-1:0] raddr;
  logic              meta_we;
  logic [PAGE_W-1:0] meta_waddr;
  meta_t             meta_wdata;
  meta_t             meta_rdata;
  logic              next_we;
  logic [PAGE_W-1:0] next_waddr;
  logic [LINK_W-1:0] next_wdata;
  logic [LINK_W-1:0] next_rdata;
  logic              prev_we;
  logic [PAGE_W-1:0] prev_waddr;
  logic [LINK_W-1:0] prev_wdata;
  logic [LINK_W-1:0] prev_rdata;

  meta_t             meta_rd;
  logic [LINK_W-1:0] nx_rd;
  logic [LINK_W-1:0] pv_rd;
  logic              found;
  logic [LI_W-1:0]   fk;
  logic [LI_W-1:0]   kn;
  logic [PAGE_W-1:0] bud;
  logic [LI_W-1:0]   clamp_k;

  bba_ram #(.WIDTH($bits(meta_t)), .DEPTH(NPAGES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(meta_waddr), .wdata(meta_wdata),
    .re(re), .raddr(raddr), .rdata(meta_rdata)
  );
  bba_ram #(.WIDTH(LINK_W), .DEPTH(NPAGES)) u_next (
    .clk(clk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
    .re(re), .raddr(raddr), .rdata(next_rdata)
  );
  bba_ram #(.WIDTH(LINK_W), .DEPTH(NPAGES)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
    .re(re), .raddr(raddr), .rdata(prev_rdata)
  );

  always_comb begin
    if (rd_vld) begin
      meta_rd = meta_rdata;
    end else begin
      meta_rd.in_use = 1'b0;
      meta_rd.order  = (rd_page == '0) ? ORD_W'(REGION_ORDER) : '0;
    end
    nx_rd = rd_init ? LINK_NONE : next_rdata;
    pv_rd = rd_init ? LINK_NONE : prev_rdata;
  end

  always_comb begin
    found = 1'b0;
    fk    = '0;
    for (int i = NORDERS - 1; i >= 0; i--) begin
      if (LI_W'(i) >= job.li && !first[i][PAGE_W]) begin
        found = 1'b1;
        fk    = LI_W'(i);
      end
    end
  end

  always_comb begin
    kn  = k - LI_W'(1);
    bud = p ^ (PAGE_W'(1) << (st == S_SPLIT ? kn : k));
    if (meta_rd.order < ORD_W'(PAGE_ORDER) || meta_rd.order > ORD_W'(REGION_ORDER)) begin
      clamp_k = '0;
    end else begin
      clamp_k = LI_W'(meta_rd.order - ORD_W'(PAGE_ORDER));
    end
  end

  always_comb begin
    job_pop    = 1'b0;
    re         = 1'b0;
    raddr      = '0;
    meta_we    = 1'b0;
    meta_waddr = p;
    meta_wdata = '0;
    next_we    = 1'b0;
    next_waddr = '0;
    next_wdata = LINK_NONE;
    prev_we    = 1'b0;
    prev_waddr = '0;
    prev_wdata = LINK_NONE;
    case (st)
      S_IDLE: begin
        if (job_valid && !res_valid) begin
          job_pop = 1'b1;
          if (job.kind == KIND_FREE) begin
            re    = 1'b1;
            raddr = job.page;
          end else if (job.kind == KIND_ALLOC && found) begin
            re    = 1'b1;
            raddr = first[fk][PAGE_W-1:0];
          end
        end
      end
      S_UNLINK: begin
        meta_we           = 1'b1;
        meta_wdata.in_use = 1'b1;
        meta_wdata.order  = ORD_W'(wi) + ORD_W'(PAGE_ORDER);
        if (!nx_rd[PAGE_W]) begin
          prev_we    = 1'b1;
          prev_waddr = nx_rd[PAGE_W-1:0];
          prev_wdata = LINK_NONE;
        end
      end
      S_SPLIT: begin
        if (k != wi) begin
          meta_we           = 1'b1;
          meta_waddr        = bud;
          meta_wdata.in_use = 1'b0;
          meta_wdata.order  = ORD_W'(kn) + ORD_W'(PAGE_ORDER);
        end
      end
      S_AP1: begin
        next_we    = 1'b1;
        next_waddr = ap_pg;
        next_wdata = LINK_NONE;
        prev_we    = 1'b1;
        prev_waddr = ap_pg;
        prev_wdata = last[k];
      end
      S_AP2: begin
        if (!tail[PAGE_W]) begin
          next_we    = 1'b1;
          next_waddr = tail[PAGE_W-1:0];
          next_wdata = {1'b0, ap_pg};
        end
      end
      S_FCHK: begin
        if (meta_rd.in_use) begin
          meta_we           = 1'b1;
          meta_wdata.in_use = 1'b0;
          meta_wdata.order  = meta_rd.order;
        end
      end
      S_FLOOP: begin
        if (k != LI_W'(NORDERS - 1)) begin
          re    = 1'b1;
          raddr = bud;
        end
      end
      S_FBUD: begin
        if (!meta_rd.in_use && meta_rd.order == ORD_W'(k) + ORD_W'(PAGE_ORDER)) begin
          if (!pv_rd[PAGE_W]) begin
            next_we    = 1'b1;
            next_waddr = pv_rd[PAGE_W-1:0];
            next_wdata = nx_rd;
          end
          if (!nx_rd[PAGE_W]) begin
            prev_we    = 1'b1;
            prev_waddr = nx_rd[PAGE_W-1:0];
            prev_wdata = pv_rd;
          end
        end
      end
      S_FFIN: begin
        meta_we           = 1'b1;
        meta_wdata.in_use = 1'b0;
        meta_wdata.order  = ORD_W'(k) + ORD_W'(PAGE_ORDER);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      res_valid  <= 1'b0;
      init_head  <= 1'b1;
      meta_valid <= '0;
      for (int i = 0; i < NORDERS; i++) begin
        first[i] <= (i == NORDERS - 1) ? LINK_W'(0) : LINK_NONE;
        last[i]  <= (i == NORDERS - 1) ? LINK_W'(0) : LINK_NONE;
      end
    end else begin
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (re) begin
        rd_page <= raddr;
        rd_vld  <= meta_valid[raddr];
        rd_init <= init_head && (raddr == '0);
      end
      if (meta_we) begin
        meta_valid[meta_waddr] <= 1'b1;
      end
      case (st)
        S_IDLE: begin
          if (job_valid && !res_valid) begin
            if (job.kind == KIND_FREE) begin
              p  <= job.page;
              st <= S_FCHK;
            end else if (job.kind == KIND_ALLOC && found) begin
              p  <= first[fk][PAGE_W-1:0];
              k  <= fk;
              wi <= job.li;
              st <= S_UNLINK;
            end else begin
              res_valid    <= 1'b1;
              status       <= 1'b1;
              block_offset <= '0;
              block_order  <= '0;
            end
          end
        end
        S_UNLINK: begin
          first[k] <= nx_rd;
          if (nx_rd[PAGE_W]) begin
            last[k] <= LINK_NONE;
          end
          st <= S_SPLIT;
        end
        S_SPLIT: begin
          if (k == wi) begin
            st <= S_DONE;
          end else begin
            k       <= kn;
            ap_pg   <= bud;
            ap_free <= 1'b0;
            st      <= S_AP1;
          end
        end
        S_AP1: begin
          tail <= last[k];
          if (last[k][PAGE_W]) begin
            first[k] <= {1'b0, ap_pg};
          end
          last[k] <= {1'b0, ap_pg};
          if (ap_pg == '0) begin
            init_head <= 1'b0;
          end
          st <= S_AP2;
        end
        S_AP2: begin
          st <= ap_free ? S_DONE : S_SPLIT;
        end
        S_FCHK: begin
          if (!meta_rd.in_use) begin
            res_valid    <= 1'b1;
            status       <= 1'b1;
            block_offset <= '0;
            block_order  <= '0;
            st           <= S_IDLE;
          end else begin
            k  <= clamp_k;
            st <= S_FLOOP;
          end
        end
        S_FLOOP: begin
          if (k == LI_W'(NORDERS - 1)) begin
            st <= S_FFIN;
          end else begin
            ap_pg <= bud;
            st    <= S_FBUD;
          end
        end
        S_FBUD: begin
          if (!meta_rd.in_use && meta_rd.order == ORD_W'(k) + ORD_W'(PAGE_ORDER)) begin
            if (pv_rd[PAGE_W]) begin
              first[k] <= nx_rd;
            end
            if (nx_rd[PAGE_W]) begin
              last[k] <= pv_rd;
            end
            if (ap_pg < p) begin
              p <= ap_pg;
            end
            k  <= k + LI_W'(1);
            st <= S_FLOOP;
          end else begin
            st <= S_FFIN;
          end
        end
        S_FFIN: begin
          ap_pg   <= p;
          ap_free <= 1'b1;
          st      <= S_AP1;
        end
        S_DONE: begin
          res_valid    <= 1'b1;
          status       <= 1'b0;
          block_offset <= {p, {PAGE_ORDER{1'b0}}};
          block_order  <= ORD_W'(k) + ORD_W'(PAGE_ORDER);
          st           <= S_IDLE;
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 1 MiB region of 4 KiB pages, orders 12 to 20.
// ----------------------------------------------------------------------------
// Command channel (cmd_valid/cmd_stall): command 0 allocates request_size
// bytes, command 1 frees the block at free_offset. A two-beat queue sits
// between the command side and the engine, so it takes up to two commands
// while the engine works or the result side stalls.
// Result channel (res_valid/res_stall): one beat per command with status,
// block_offset and block_order. A held result keeps its value until taken,
// and the engine starts no new job while a result waits.
// An allocate takes longer for each split level and a free for each merge
// level. The engine takes the next job in the cycle after its result is
// taken. The time a job takes is set by the engine's walk over the page
// table and link memories, one registered-read access per step.
// Reset: synchronous; the whole region becomes one free block of order 20
// at once, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module buddy_block_allocator import bba_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cmd_valid,
  output logic                         cmd_stall,
  input  wire logic                    command,
  input  wire logic [SIZE_W-1:0]       request_size,
  input  wire logic [REGION_ORDER-1:0] free_offset,
  output logic                         res_valid,
  input  wire logic                    res_stall,
  output logic                         status,
  output logic [REGION_ORDER-1:0]      block_offset,
  output logic [ORD_W-1:0]             block_order
);

  job_t job;
  logic job_valid;
  logic job_pop;

  bba_front u_front (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .command(command), .request_size(request_size), .free_offset(free_offset),
    .job(job), .job_valid(job_valid), .job_pop(job_pop)
  );

  bba_back u_back (
    .clk(clk), .rst(rst),
    .job(job), .job_valid(job_valid), .job_pop(job_pop),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .block_offset(block_offset), .block_order(block_order)
  );

endmodule
`default_nettype wire

// File: verif/bba_checker.sv
// ----------------------------------------------------------------------------
// bba_checker
// Watches the command and result channels of the buddy block allocator,
// keeps its own copy of the page table and free lists, predicts each result
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module bba_checker import bba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_valid,
  input  logic                    cmd_stall,
  input  logic                    command,
  input  logic [SIZE_W-1:0]       request_size,
  input  logic [REGION_ORDER-1:0] free_offset,
  input  logic                    res_valid,
  input  logic                    res_stall,
  input  logic                    status,
  input  logic [REGION_ORDER-1:0] block_offset,
  input  logic [ORD_W-1:0]        block_order,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                    status;
    logic [REGION_ORDER-1:0] offset;
    logic [ORD_W-1:0]        order;
  } grant_t;

  logic              used [NPAGES];
  logic [ORD_W-1:0]  ord  [NPAGES];
  logic [LINK_W-1:0] nxt  [NPAGES];
  logic [LINK_W-1:0] prv  [NPAGES];
  logic [LINK_W-1:0] head [NORDERS];
  logic [LINK_W-1:0] tail [NORDERS];
  grant_t            grants_due[$];

  task automatic clear_lists();
    for (int i = 0; i < NPAGES; i++) begin
      used[i] = 1'b0;
      ord[i]  = '0;
      nxt[i]  = LINK_NONE;
      prv[i]  = LINK_NONE;
    end
    for (int i = 0; i < NORDERS; i++) begin
      head[i] = LINK_NONE;
      tail[i] = LINK_NONE;
    end
    ord[0]           = ORD_W'(REGION_ORDER);
    head[NORDERS-1]  = '0;
    tail[NORDERS-1]  = '0;
  endtask

  task automatic unlink(input int p, input int li);
    logic [LINK_W-1:0] pv, nx;
    pv = prv[p];
    nx = nxt[p];
    if (pv != LINK_NONE) nxt[pv[PAGE_W-1:0]] = nx; else head[li] = nx;
    if (nx != LINK_NONE) prv[nx[PAGE_W-1:0]] = pv; else tail[li] = pv;
    nxt[p] = LINK_NONE;
    prv[p] = LINK_NONE;
  endtask

  task automatic append(input int p, input int li);
    logic [LINK_W-1:0] t;
    t = tail[li];
    nxt[p] = LINK_NONE;
    prv[p] = t;
    if (t != LINK_NONE) nxt[t[PAGE_W-1:0]] = LINK_W'(p); else head[li] = LINK_W'(p);
    tail[li] = LINK_W'(p);
  endtask

  function automatic grant_t make_grant(logic st, int p, int k);
    grant_t g;
    g.status = st;
    g.offset = REGION_ORDER'(p << PAGE_ORDER);
    g.order  = ORD_W'(k);
    return g;
  endfunction

  task automatic grant_block(input logic [SIZE_W-1:0] size, output grant_t g);
    int want, k, p, q;
    want = PAGE_ORDER;
    while (want < REGION_ORDER && (64'd1 << want) < size) want++;
    g = make_grant(1'b1, 0, 0);
    if ((64'd1 << want) < size) return;
    k = want;
    while (k <= REGION_ORDER && head[k-PAGE_ORDER] == LINK_NONE) k++;
    if (k > REGION_ORDER) return;
    p = head[k-PAGE_ORDER];
    unlink(p, k - PAGE_ORDER);
    used[p] = 1'b1;
    while (k > want) begin
      k--;
      q = (p ^ (1 << (k - PAGE_ORDER))) & (NPAGES - 1);
      ord[q]  = ORD_W'(k);
      used[q] = 1'b0;
      append(q, k - PAGE_ORDER);
    end
    ord[p] = ORD_W'(want);
    g = make_grant(1'b0, p, want);
  endtask

  task automatic release_block(input logic [REGION_ORDER-1:0] off, output grant_t g);
    int p, k, q;
    p = off[REGION_ORDER-1:PAGE_ORDER];
    g = make_grant(1'b1, 0, 0);
    if (!used[p]) return;
    used[p] = 1'b0;
    k = ord[p];
    if (k < PAGE_ORDER || k > REGION_ORDER) k = PAGE_ORDER;
    while (k < REGION_ORDER) begin
      q = (p ^ (1 << (k - PAGE_ORDER))) & (NPAGES - 1);
      if (used[q] || ord[q] != k) break;
      unlink(q, k - PAGE_ORDER);
      if (q < p) p = q;
      k++;
    end
    ord[p] = ORD_W'(k);
    append(p, k - PAGE_ORDER);
    g = make_grant(1'b0, p, k);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("bba_checker: %s mismatch at %0t: got %0d, want %0d", what, $realtime, got, want);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    clear_lists();
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst) begin
      clear_lists();
      grants_due.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (grants_due.size() == 0) begin
          $display("bba_checker: unexpected result beat at %0t", $realtime);
          errors++;
        end else begin
          g = grants_due.pop_front();
          if (status != g.status) report("status", status, g.status);
          if (block_offset != g.offset) report("block_offset", block_offset, g.offset);
          if (block_order != g.order) report("block_order", block_order, g.order);
        end
      end
      if (cmd_valid && !cmd_stall) begin
        if (command) release_block(free_offset, g);
        else grant_block(request_size, g);
        grants_due.push_back(g);
      end
    end
    pending = grants_due.size();
  end
endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives the buddy block allocator with directed and random allocate/free
// beats under random gaps and result stalls; the checker predicts and
// compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb import bba_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
  localparam int   N_RANDOM  = 1200;
  localparam int   LIMIT     = 600000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cmd_valid = 1'b0;
  logic                    cmd_stall;
  logic                    command = CMD_ALLOC;
  logic [SIZE_W-1:0]       request_size = '0;
  logic [REGION_ORDER-1:0] free_offset = '0;
  logic                    res_valid;
  logic                    res_stall = 1'b0;
  logic                    status;
  logic [REGION_ORDER-1:0] block_offset;
  logic [ORD_W-1:0]        block_order;
  int                      errors, pending;
  int                      cycles = 0;
  bit                      busy_mode = 1'b1;
  logic                    kinds_sent[$];
  logic [REGION_ORDER-1:0] held[$];
  int                      n_alloc = 0, n_free = 0, n_granted = 0;

  buddy_block_allocator u_dut (.*);
  bba_checker u_chk (.*);

  initial forever #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: done, errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    logic k;
    if (!rst && cmd_valid && !cmd_stall) kinds_sent.push_back(command);
    if (!rst && res_valid && !res_stall && kinds_sent.size() > 0) begin
      k = kinds_sent.pop_front();
      if (k == CMD_ALLOC && status == 1'b0) begin
        held.push_back(block_offset);
        n_granted++;
      end
    end
  end

  initial begin
    int n;
    @(negedge clk);
    wait (!rst);
    forever begin
      n = busy_mode ? $urandom_range(14, 0) : 0;
      repeat (n) begin
        @(negedge clk);
        res_stall <= 1'b1;
      end
      @(negedge clk);
      res_stall <= 1'b0;
      do @(posedge clk); while (!res_valid);
    end
  end

  task automatic send(input logic c, input logic [SIZE_W-1:0] sz,
                      input logic [REGION_ORDER-1:0] off);
    int gap;
    gap = busy_mode ? $urandom_range(14, 0) : 0;
    if (gap > 0) begin
      @(negedge clk);
      cmd_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid    <= 1'b1;
    command      <= c;
    request_size <= sz;
    free_offset  <= off;
    do @(posedge clk); while (cmd_stall);
    if (c == CMD_ALLOC) n_alloc++; else n_free++;
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (pending != 0 || kinds_sent.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int idx, o;
    logic [REGION_ORDER-1:0] off;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    busy_mode = 1'b0;
    send(CMD_ALLOC, 21'd0, '0);
    send(CMD_FREE, '0, 20'h00fff);
    send(CMD_ALLOC, 21'h100000, '0);
    send(CMD_ALLOC, 21'd1, '0);
    send(CMD_FREE, '0, 20'hfffff);
    send(CMD_FREE, '0, 20'h00000);
    send(CMD_ALLOC, 21'h100001, '0);
    send(CMD_ALLOC, 21'h1fffff, '0);
    send(CMD_ALLOC, 21'd4096, '0);
    send(CMD_ALLOC, 21'd4097, '0);
    send(CMD_ALLOC, 21'd8192, '0);
    send(CMD_ALLOC, 21'h80000, '0);
    send(CMD_ALLOC, 21'h80000, '0);
    send(CMD_FREE, '0, 20'h01000);
    send(CMD_FREE, '0, 20'h02000);
    send(CMD_FREE, '0, 20'h04000);
    send(CMD_FREE, '0, 20'h00000);
    send(CMD_FREE, '0, 20'hff000);
    send(CMD_ALLOC, 21'h0aaaaa, '0);
    send(CMD_ALLOC, 21'h055555, '0);
    drain();

    busy_mode = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 150 == 0) busy_mode = ($urandom_range(3, 0) != 0);
      if (i == N_RANDOM / 2) drain();
      if ($urandom_range(99, 0) < 80) begin
        if (held.size() > 0 && $urandom_range(99, 0) < 48) begin
          idx = $urandom_range(held.size() - 1, 0);
          off = held[idx];
          held.delete(idx);
          off[PAGE_ORDER-1:0] = PAGE_ORDER'($urandom);
          send(CMD_FREE, SIZE_W'($urandom), off);
        end else begin
          o = ($urandom_range(99, 0) < 85) ? $urandom_range(15, 12) : $urandom_range(20, 16);
          send(CMD_ALLOC, SIZE_W'($urandom_range(1 << o, 1)), REGION_ORDER'($urandom));
        end
      end else begin
        case ($urandom_range(3, 0))
          0: send(CMD_ALLOC, '0, REGION_ORDER'($urandom));
          1: send(CMD_ALLOC, SIZE_W'($urandom_range(21'h1fffff, 21'h100001)), '0);
          default: send(CMD_FREE, SIZE_W'($urandom), REGION_ORDER'($urandom));
        endcase
      end
    end
    drain();

    $display("tb: %0d allocate beats (%0d granted), %0d free beats", n_alloc, n_granted,
             n_free);
    $display("tb: directed extremes, random sizes and frees, gaps and stalls on both sides");
    if (errors == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule

// File: sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/bba_front.sv
rtl/bba_back.sv
rtl/buddy_block_allocator.sv
verif/bba_checker.sv
verif/tb.sv
